/* rtl/rpnsa_pkg.sv */
// ----------------------------------------------------------------------------
// rpnsa_pkg
// Shared constants, codes and controller/datapath types for the RPN stack ALU.
// ----------------------------------------------------------------------------
package rpnsa_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 4;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int ST_W        = 2;

  // iterative divider: one quotient bit per step
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // request codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_OP   = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic calc;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_div;
    logic div_zero;
    logic div_done;
  } dp_sts_t;

endpackage

/* rtl/rpnsa_req_if.sv */
// ----------------------------------------------------------------------------
// rpnsa_req_if
// Request channel: one item is a push or a binary operation.
// ----------------------------------------------------------------------------
interface rpnsa_req_if;
  import rpnsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

/* rtl/rpnsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// rpnsa_rsp_if
// Result channel: all four stack levels and a status for every item.
// ----------------------------------------------------------------------------
interface rpnsa_rsp_if;
  import rpnsa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] x_out;
  logic signed [DATA_W-1:0] y_out;
  logic signed [DATA_W-1:0] z_out;
  logic signed [DATA_W-1:0] t_out;
  logic [ST_W-1:0]          status;

  modport source (output valid, output x_out, output y_out, output z_out,
                  output t_out, output status, input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out,
                  input t_out, input status, output ready);
endinterface

/* rtl/rpnsa_div.sv */
// ----------------------------------------------------------------------------
// rpnsa_div
// Radix-2 restoring divider, signed operands, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rpnsa_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               step_i,
  input  logic signed [rpnsa_pkg::DATA_W-1:0] num_i,
  input  logic signed [rpnsa_pkg::DATA_W-1:0] den_i,
  output logic signed [rpnsa_pkg::DATA_W-1:0] quo_o,
  output logic                               done_o
);
  import rpnsa_pkg::*;

  logic [DATA_W-1:0]    rem_q, rem_d;
  logic [DATA_W-1:0]    quo_q, quo_d;
  logic [DATA_W-1:0]    den_q;
  logic                 neg_q;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    num_mag, den_mag;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W+1:0]    diff;

  // operand magnitudes (most negative value maps to 2^31 unsigned)
  assign num_mag = num_i[DATA_W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[DATA_W-1] ? (~den_i + 1'b1) : den_i;

  // one trial subtraction per step
  assign rem_sh = {rem_q, quo_q[DATA_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_mag;
      cnt_d = '0;
    end else if (step_i) begin
      cnt_d = cnt_q + 1'b1;
      if (!diff[DATA_W+1]) begin
        rem_d = diff[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DATA_W-1:0];
        quo_d = {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_mag;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end
  end

  assign done_o = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign quo_o  = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

/* rtl/rpnsa_dp.sv */
// ----------------------------------------------------------------------------
// rpnsa_dp
// Datapath: stack levels, arithmetic unit, divider and result register.
// ----------------------------------------------------------------------------
module rpnsa_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rpnsa_pkg::dp_cmd_t                 cmd_i,
  output rpnsa_pkg::dp_sts_t                 sts_o,
  input  logic [rpnsa_pkg::OP_W-1:0]         req_type_i,
  input  logic signed [rpnsa_pkg::DATA_W-1:0] push_value_i,
  output logic signed [rpnsa_pkg::DATA_W-1:0] x_out_o,
  output logic signed [rpnsa_pkg::DATA_W-1:0] y_out_o,
  output logic signed [rpnsa_pkg::DATA_W-1:0] z_out_o,
  output logic signed [rpnsa_pkg::DATA_W-1:0] t_out_o,
  output logic [rpnsa_pkg::ST_W-1:0]         status_o
);
  import rpnsa_pkg::*;

  logic [DATA_W-1:0] stk_q [STACK_DEPTH];
  logic [DATA_W-1:0] stk_d [STACK_DEPTH];
  logic [DATA_W-1:0] drop_src [STACK_DEPTH+1];
  logic [DATA_W-1:0] lvl_next [4];
  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] res_q;
  logic [DATA_W-1:0] res_fin;
  logic [DATA_W-1:0] x_lvl, y_lvl;
  logic [DATA_W-1:0] div_quo;
  logic              div_done;
  logic [ST_W-1:0]   status_w;
  logic [DATA_W-1:0] x_q, y_q, z_q, t_q;
  logic [ST_W-1:0]   status_q;

  assign x_lvl = stk_q[0];
  assign y_lvl = stk_q[1];

  // capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= req_type_i;
      val_q <= push_value_i;
    end
  end

  // add, subtract and multiply, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      case (op_q)
        OP_ADD:  res_q <= y_lvl + x_lvl;
        OP_SUB:  res_q <= y_lvl - x_lvl;
        OP_MUL:  res_q <= y_lvl * x_lvl;
        default: res_q <= '0;
      endcase
    end
  end

  rpnsa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.calc),
    .step_i (cmd_i.div_step),
    .num_i  (y_lvl),
    .den_i  (x_lvl),
    .quo_o  (div_quo),
    .done_o (div_done)
  );

  // status of the pending item
  always_comb begin
    status_w = ST_OK;
    if (op_q > OP_DIV) begin
      status_w = ST_BAD_OP;
    end else if (op_q == OP_DIV && x_lvl == '0) begin
      status_w = ST_DIV_ZERO;
    end
  end

  assign sts_o.is_div   = (op_q == OP_DIV);
  assign sts_o.div_zero = (x_lvl == '0);
  assign sts_o.div_done = div_done;

  assign res_fin = (op_q == OP_DIV) ? div_quo : res_q;

  // levels seen from one place higher, with zero above the top
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      drop_src[i] = stk_q[i];
    end
    drop_src[STACK_DEPTH] = '0;
  end

  // next stack contents
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stk_d[i] = stk_q[i];
    end
    if (op_q == OP_PUSH) begin
      stk_d[0] = val_q;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk_d[i] = stk_q[i-1];
      end
    end else if (status_w == ST_OK) begin
      stk_d[0] = res_fin;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk_d[i] = drop_src[i+1];
      end
    end
  end

  // reported levels, missing ones read as zero
  for (genvar k = 0; k < 4; k++) begin : g_lvl
    if (k < STACK_DEPTH) begin : g_have
      assign lvl_next[k] = stk_d[k];
    end else begin : g_none
      assign lvl_next[k] = '0;
    end
  end

  // stack registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        stk_q[i] <= stk_d[i];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      x_q      <= lvl_next[0];
      y_q      <= lvl_next[1];
      z_q      <= lvl_next[2];
      t_q      <= lvl_next[3];
      status_q <= status_w;
    end
  end

  assign x_out_o  = x_q;
  assign y_out_o  = y_q;
  assign z_out_o  = z_q;
  assign t_out_o  = t_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  // a push lands its value in level x
  a_push_to_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && op_q == OP_PUSH |=> stk_q[0] == $past(val_q))
    else $error("push value not in level x");

  // an error leaves levels x and y as they were
  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && status_w != ST_OK |=>
      stk_q[0] == $past(stk_q[0]) && stk_q[1] == $past(stk_q[1]))
    else $error("stack changed on error");

  // a completed operation clears the top level
  a_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && op_q != OP_PUSH && status_w == ST_OK |=>
      stk_q[STACK_DEPTH-1] == '0)
    else $error("top level not cleared after operation");

  // result register shows the committed level x
  a_out_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> x_q == stk_q[0])
    else $error("result x differs from stack");
`endif

endmodule

/* rtl/rpnsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rpnsa_ctrl
// Controller: sequences accept, calculate and commit for each item, and divide for a non-zero divisor.
// ----------------------------------------------------------------------------
module rpnsa_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output rpnsa_pkg::dp_cmd_t cmd_o,
  input  rpnsa_pkg::dp_sts_t sts_i
);
  import rpnsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_DIV,
    S_APPLY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept, commit;

  assign accept = (state_q == S_IDLE) && req_valid_i;
  assign commit = (state_q == S_APPLY) && (!out_valid_q || rsp_ready_i);

  // next state and result valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        if (sts_i.is_div && !sts_i.div_zero) begin
          state_d = S_DIV;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        if (commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o     = (state_q == S_IDLE);
  assign rsp_valid_o     = out_valid_q;
  assign cmd_o.accept    = accept;
  assign cmd_o.calc      = (state_q == S_CALC);
  assign cmd_o.div_step  = (state_q == S_DIV);
  assign cmd_o.commit    = commit;

`ifndef SYNTHESIS
  // a new result appears only after a commit
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(commit))
    else $error("result valid without commit");

  // the divider runs only for a divide with a non-zero divisor
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CALC && !(sts_i.is_div && !sts_i.div_zero) |=> state_q == S_APPLY)
    else $error("divider entered without a divide");

  // commit never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> !out_valid_q || rsp_ready_i)
    else $error("result overwritten");
`endif

endmodule

/* rtl/rpn_four_level_stack_alu_unit.sv */
// Sequence: an item is accepted in S_IDLE and worked in S_CALC; a divide with a
//   non-zero divisor then runs the radix-2 divider in S_DIV, one quotient bit a
//   cycle; S_APPLY commits it once the result register is free or being read.
// Items: one at a time; no new item is accepted until the last one is committed.
// Reset: asynchronous, clears all stack levels to zero and empties the result.
// ----------------------------------------------------------------------------
// rpn_four_level_stack_alu_unit
// Four-level RPN stack ALU: push or apply Y op X, report stack and status.
// ----------------------------------------------------------------------------
module rpn_four_level_stack_alu_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  rpnsa_req_if.sink     req_i,
  rpnsa_rsp_if.source   rsp_o
);
  import rpnsa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing
  rpnsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .req_ready_o(req_i.ready),
    .rsp_valid_o(rsp_o.valid),
    .rsp_ready_i(rsp_o.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // stack and arithmetic
  rpnsa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_i.req_type),
    .push_value_i(req_i.push_value),
    .x_out_o     (rsp_o.x_out),
    .y_out_o     (rsp_o.y_out),
    .z_out_o     (rsp_o.z_out),
    .t_out_o     (rsp_o.t_out),
    .status_o    (rsp_o.status)
  );

endmodule

/* tb/rpn_four_level_stack_alu_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_four_level_stack_alu_unit_tb
// Drives push and operator items into the RPN stack ALU. It keeps its own
// copy of the X/Y/Z/T stack to predict every result. Each returned stack
// image and status is checked in order. It runs under three idling mixes.
// ----------------------------------------------------------------------------
module rpn_four_level_stack_alu_unit_tb;
  import rpnsa_pkg::*;

  localparam logic [DATA_W-1:0] MOST_NEG   = 32'h8000_0000;
  localparam logic [DATA_W-1:0] MOST_POS   = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] MINUS_ONE  = 32'hffff_ffff;
  localparam logic [OP_W-1:0]   OP_BAD_LO  = OP_DIV + 3'd1;
  localparam logic [OP_W-1:0]   OP_BAD_HI  = '1;
  localparam int                DRAIN_CYCLES = 40;
  localparam int                MAX_REPORTS  = 20;

  // one stack image with its status, as returned per item
  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] t;
    logic [ST_W-1:0]   status;
  } stack_view_t;

  logic clk_i;
  logic rst_ni;

  rpnsa_req_if req_if ();
  rpnsa_rsp_if rsp_if ();

  rpn_four_level_stack_alu_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted stack and pending stack images
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  stack_view_t       pending_views [$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int views_checked;
  int push_count;
  int arith_count;
  int div_zero_count;
  int bad_op_count;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard limit on run length
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  // stack update for one key, returns the image the block should show
  function automatic stack_view_t apply_key(input logic [OP_W-1:0] op,
                                            input logic [DATA_W-1:0] val);
    stack_view_t       view;
    logic [DATA_W-1:0] xv;
    logic [DATA_W-1:0] yv;
    logic [DATA_W-1:0] res;
    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [ST_W-1:0]   st;
    int                i;
    st  = ST_OK;
    xv  = calc_stack[0];
    yv  = calc_stack[1];
    res = '0;
    if (op == OP_PUSH) begin
      for (i = STACK_DEPTH - 1; i > 0; i--) calc_stack[i] = calc_stack[i-1];
      calc_stack[0] = val;
    end else if (op > OP_DIV) begin
      st = ST_BAD_OP;
    end else begin
      case (op)
        OP_ADD: res = yv + xv;
        OP_SUB: res = yv - xv;
        OP_MUL: res = yv * xv;
        default: begin
          // divide on magnitudes, then fix the sign: truncates toward zero
          if (xv == '0) begin
            st = ST_DIV_ZERO;
          end else begin
            num_mag = yv[DATA_W-1] ? -yv : yv;
            den_mag = xv[DATA_W-1] ? -xv : xv;
            res     = num_mag / den_mag;
            if (yv[DATA_W-1] ^ xv[DATA_W-1]) res = -res;
          end
        end
      endcase
      // result into X, upper levels drop, top clears
      if (st == ST_OK) begin
        calc_stack[0] = res;
        for (i = 1; i < STACK_DEPTH - 1; i++) calc_stack[i] = calc_stack[i+1];
        calc_stack[STACK_DEPTH-1] = '0;
      end
    end
    view.x      = calc_stack[0];
    view.y      = calc_stack[1];
    view.z      = calc_stack[2];
    view.t      = calc_stack[3];
    view.status = st;
    return view;
  endfunction

  // send one item, with a random gap first; valid stays high on return
  task automatic send_key(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    stack_view_t view;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= OP_W'($urandom);
      req_if.push_value <= $urandom;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= op;
    req_if.push_value <= val;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    view = apply_key(op, val);
    pending_views.push_back(view);
    if (op == OP_PUSH) push_count++;
    else if (op > OP_DIV) bad_op_count++;
    else arith_count++;
    if (view.status == ST_DIV_ZERO) div_zero_count++;
  endtask

  // stop sending until every pending image has come back
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, check each image against the oldest prediction
  always @(posedge clk_i) begin
    stack_view_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_views.size() == 0) begin
        report_mismatch($sformatf("result with none expected, x %08h status %0d",
                                  rsp_if.x_out, rsp_if.status));
      end else begin
        want = pending_views.pop_front();
        views_checked++;
        if (rsp_if.x_out !== want.x)
          report_mismatch($sformatf("x got %08h want %08h", rsp_if.x_out, want.x));
        if (rsp_if.y_out !== want.y)
          report_mismatch($sformatf("y got %08h want %08h", rsp_if.y_out, want.y));
        if (rsp_if.z_out !== want.z)
          report_mismatch($sformatf("z got %08h want %08h", rsp_if.z_out, want.z));
        if (rsp_if.t_out !== want.t)
          report_mismatch($sformatf("t got %08h want %08h", rsp_if.t_out, want.t));
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    rsp_if.status, want.status));
      end
    end
    rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // operations on the cleared stack, including divide by zero
  task automatic test_empty_stack();
    send_key(OP_ADD, $urandom);
    send_key(OP_DIV, $urandom);
    send_key(OP_BAD_LO, $urandom);
  endtask

  // extreme values fill all four levels, then errors leave them alone
  task automatic test_push_extremes();
    send_key(OP_PUSH, MOST_POS);
    send_key(OP_PUSH, MOST_NEG);
    send_key(OP_PUSH, MINUS_ONE);
    send_key(OP_PUSH, '0);
    send_key(OP_DIV, $urandom);
    send_key(OP_BAD_LO + 3'd1, $urandom);
    send_key(OP_BAD_HI, $urandom);
  endtask

  // add, subtract and multiply wrapping past 32 bits
  task automatic test_wrapping_arith();
    send_key(OP_PUSH, MOST_POS);
    send_key(OP_PUSH, 32'd1);
    send_key(OP_ADD, $urandom);
    send_key(OP_PUSH, MOST_NEG);
    send_key(OP_PUSH, 32'd1);
    send_key(OP_SUB, $urandom);
    send_key(OP_PUSH, 32'h0001_0000);
    send_key(OP_PUSH, 32'h0001_0000);
    send_key(OP_MUL, $urandom);
  endtask

  // most negative over minus one, and truncation of a negative quotient
  task automatic test_division_rules();
    send_key(OP_PUSH, MOST_NEG);
    send_key(OP_PUSH, MINUS_ONE);
    send_key(OP_DIV, $urandom);
    send_key(OP_PUSH, -32'sd7);
    send_key(OP_PUSH, 32'd2);
    send_key(OP_DIV, $urandom);
  endtask

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return MINUS_ONE;
      4, 5:    return DATA_W'($urandom_range(40)) - 32'd20;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_operator();
    int r;
    r = $urandom_range(99);
    if (r < 25) return OP_ADD;
    if (r < 47) return OP_SUB;
    if (r < 69) return OP_MUL;
    return OP_DIV;
  endfunction

  // mostly short expressions (pushes then operators), some stray keys
  task automatic test_random_expressions(input int num_items);
    int sent;
    int k;
    int n_push;
    int n_ops;
    sent = 0;
    while (sent < num_items) begin
      if ($urandom_range(9) == 0) begin
        if ($urandom_range(1)) send_key(OP_W'($urandom_range(OP_BAD_HI, OP_BAD_LO)), $urandom);
        else send_key(pick_operator(), $urandom);
        sent++;
      end else begin
        n_push = $urandom_range(3, 1);
        n_ops  = $urandom_range(3, 1);
        for (k = 0; k < n_push; k++) send_key(OP_PUSH, pick_operand());
        for (k = 0; k < n_ops; k++) send_key(pick_operator(), $urandom);
        sent += n_push + n_ops;
      end
    end
  endtask

  initial begin
    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.req_type   = OP_PUSH;
    req_if.push_value = '0;
    error_count       = 0;
    views_checked     = 0;
    push_count        = 0;
    arith_count       = 0;
    div_zero_count    = 0;
    bad_op_count      = 0;
    send_idle_pct     = 22;
    recv_idle_pct     = 81;
    for (int i = 0; i < STACK_DEPTH; i++) calc_stack[i] = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender sparse gaps, receiver mostly stalled
    test_empty_stack();
    test_push_extremes();
    test_wrapping_arith();
    test_division_rules();
    test_random_expressions(70);
    wait_for_results();
    test_random_expressions(65);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 81;
    recv_idle_pct = 22;
    test_random_expressions(135);

    // full rate both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_expressions(135);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d stack images: %0d pushes, %0d operations", views_checked,
             push_count, arith_count);
    $display("  %0d divides by zero, %0d invalid codes, three idling mixes",
             div_zero_count, bad_op_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rpnsa_pkg.sv
rtl/rpnsa_req_if.sv
rtl/rpnsa_rsp_if.sv
rtl/rpnsa_div.sv
rtl/rpnsa_dp.sv
rtl/rpnsa_ctrl.sv
rtl/rpn_four_level_stack_alu_unit.sv
tb/rpn_four_level_stack_alu_unit_tb.sv
